### design/srtc_pkg.sv
// Shared types, register offsets and helper functions of the seconds real-time clock.
package srtc_pkg;

  // Transaction kinds on the input channel.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Access sizes; the fourth code behaves as a word access.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Register byte offsets.
  localparam logic [11:0] OFF_DATA    = 12'h000;
  localparam logic [11:0] OFF_MATCH   = 12'h004;
  localparam logic [11:0] OFF_LOAD    = 12'h008;
  localparam logic [11:0] OFF_CONTROL = 12'h00C;
  localparam logic [11:0] OFF_MASK    = 12'h010;
  localparam logic [11:0] OFF_RAW     = 12'h014;
  localparam logic [11:0] OFF_MASKED  = 12'h018;
  localparam logic [11:0] OFF_CLEAR   = 12'h01C;

  // The identification window spans 0xFE0 up to the end of the 4 KiB window,
  // so it is every offset whose upper seven bits are all ones.
  localparam logic [6:0] ID_WINDOW_TAG = 7'h7F;

  localparam logic [31:0] LANES_BYTE = 32'hFFFF_FFFF >> 24;
  localparam logic [31:0] LANES_HALF = 32'hFFFF_FFFF >> 16;
  localparam logic [31:0] LANES_WORD = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
  } srtc_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        irq_level;
  } srtc_out_t;

  // Byte lanes touched by an access of the given size.
  function automatic logic [31:0] lane_mask(input logic [1:0] size);
    logic [31:0] lanes;
    unique case (size)
      SIZE_BYTE: lanes = LANES_BYTE;
      SIZE_HALF: lanes = LANES_HALF;
      default:   lanes = LANES_WORD;
    endcase
    return lanes;
  endfunction

  // Identification bytes, one per 32-bit word of the identification window.
  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h31;
      3'd1: b = 8'h10;
      3'd2: b = 8'h14;
      3'd3: b = 8'h00;
      3'd4: b = 8'h0d;
      3'd5: b = 8'hf0;
      3'd6: b = 8'h05;
      3'd7: b = 8'hb1;
    endcase
    return b;
  endfunction

endpackage

### design/seconds_rtc_with_match_alarm.sv
// Seconds real-time clock with a match alarm: register file, counter and interrupt logic.
//
// This block is a seconds real-time clock seen through a small register window. Every
// input transaction is a bus read, a bus write (byte, halfword or word) or a one-second
// tick, and every input transaction yields exactly one result transaction carrying the
// read data, an access error flag and the interrupt level after that transaction. The
// block takes one transaction per clock cycle while the result consumer keeps up: a
// transaction is captured in an input register, and once the output register is free
// it is decoded, the state is updated and the result is loaded into the output
// register. The input register and the output register each hold one transaction, so
// a stalled result consumer lets one more transaction be taken before in_ready drops.
// The counter increments, the load path and the match compare all resolve
// combinationally in the decode step.
module seconds_rtc_with_match_alarm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srtc_pkg::srtc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srtc_pkg::srtc_out_t out_data
);
  import srtc_pkg::*;

  // Input stage.
  logic      s1_valid_r;
  srtc_in_t  s1_data_r;

  // Output stage.
  logic      out_valid_r;
  srtc_out_t out_data_r;

  // Architectural state of the clock.
  logic [31:0] seconds_count_r;
  logic [31:0] match_value_r;
  logic [31:0] load_value_r;
  logic        irq_mask_r;
  logic        raw_status_r;

  logic [31:0] seconds_count_nxt;
  logic [31:0] match_value_nxt;
  logic [31:0] load_value_nxt;
  logic        irq_mask_nxt;
  logic        raw_status_nxt;

  logic        advance;
  logic [31:0] lanes;
  logic [31:0] wdata;
  logic [31:0] rd_raw;
  logic        err;
  logic        check_match;
  srtc_out_t   result;

  // The staged transaction moves on whenever the output register is empty or is being
  // emptied in this cycle; the input register refills in the same cycle it drains.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lanes = lane_mask(s1_data_r.access_size);
  assign wdata = s1_data_r.write_data & lanes;

  // Decode of one transaction against the current state.
  always_comb begin
    seconds_count_nxt = seconds_count_r;
    match_value_nxt   = match_value_r;
    load_value_nxt    = load_value_r;
    irq_mask_nxt      = irq_mask_r;
    raw_status_nxt    = raw_status_r;
    rd_raw            = '0;
    err               = 1'b0;
    check_match       = 1'b0;

    unique case (s1_data_r.command)
      CMD_READ: begin
        if (s1_data_r.offset[11:5] == ID_WINDOW_TAG) begin
          // Each identification byte sits in its own word; any byte address in
          // that word returns it.
          rd_raw = {24'b0, id_byte(s1_data_r.offset[4:2])};
        end else begin
          unique case (s1_data_r.offset)
            OFF_DATA:    rd_raw = seconds_count_r;
            OFF_MATCH:   rd_raw = match_value_r;
            OFF_LOAD:    rd_raw = load_value_r;
            OFF_CONTROL: rd_raw = 32'd1;
            OFF_MASK:    rd_raw = {31'b0, irq_mask_r};
            OFF_RAW:     rd_raw = {31'b0, raw_status_r};
            OFF_MASKED:  rd_raw = {31'b0, raw_status_r & irq_mask_r};
            default:     err    = 1'b1;
          endcase
        end
      end
      CMD_WRITE: begin
        unique case (s1_data_r.offset)
          OFF_MATCH: begin
            // Narrow writes replace only the low lanes and keep the rest.
            match_value_nxt = (match_value_r & ~lanes) | wdata;
            check_match     = 1'b1;
          end
          OFF_LOAD: begin
            load_value_nxt    = (load_value_r & ~lanes) | wdata;
            seconds_count_nxt = (load_value_r & ~lanes) | wdata;
            check_match       = 1'b1;
          end
          OFF_CONTROL: begin
            // The clock is always enabled; the write is accepted and dropped.
          end
          OFF_MASK:  irq_mask_nxt   = wdata[0];
          OFF_CLEAR: raw_status_nxt = 1'b0;
          default:   err            = 1'b1;
        endcase
      end
      CMD_TICK: begin
        seconds_count_nxt = seconds_count_r + 32'd1;
        check_match       = 1'b1;
      end
      default: begin
        // Unused command code: no operation.
      end
    endcase

    // Status is sticky; it is set by a match and only cleared by the clear register or by reset.
    if (check_match && (seconds_count_nxt == match_value_nxt)) begin
      raw_status_nxt = 1'b1;
    end

    result.read_data    = err ? '0 : (rd_raw & lanes);
    result.access_error = err;
    result.irq_level    = raw_status_nxt & irq_mask_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      seconds_count_r <= '0;
      match_value_r   <= '0;
      load_value_r    <= '0;
      irq_mask_r      <= 1'b0;
      raw_status_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r     <= 1'b1;
        seconds_count_r <= seconds_count_nxt;
        match_value_r   <= match_value_nxt;
        load_value_r    <= load_value_nxt;
        irq_mask_r      <= irq_mask_nxt;
        raw_status_r    <= raw_status_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  // The reported interrupt level matches the state left behind by the transaction.
  a_irq_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_data_r.irq_level == (raw_status_r & irq_mask_r)))
    else $error("irq level does not match mask and status state");

  // A tick advances the counter by exactly one.
  a_tick_increments: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_data_r.command == CMD_TICK))
      |=> (seconds_count_r == $past(seconds_count_r) + 32'd1))
    else $error("tick did not increment the seconds counter");

  // Only reads return data.
  a_no_data_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_data_r.command != CMD_READ)) |=> (out_data_r.read_data == '0))
    else $error("non-read transaction returned data");

  // The data register is read-only: a write errors and leaves the counter alone.
  a_data_write_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_data_r.command == CMD_WRITE) && (s1_data_r.offset == OFF_DATA))
      |=> (out_data_r.access_error && $stable(seconds_count_r)))
    else $error("write to the data register was not rejected");

  // A staged transaction is never dropped while the output is blocked.
  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("staged transaction lost");

endmodule
